/* rtl/core/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// Window median filter package
// Field widths, register indexes, reset values and the structs passed
// between the front end, the window queue and the sorting back end.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
  } wmf_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } wmf_meta_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } wmf_qstat_t;

endpackage

/* rtl/core/window_median_filter_unit.sv */
// ----------------------------------------------------------------------------
// Window median filter unit
// Square-window median over a raster stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Input channel: one pixel per transfer (in_valid / in_stall), raster order;
//   frame_start on a pixel restarts the row and column counters.
// Output channel: one result per interior centre (out_valid / out_stall)
//   with the median, the centre row and column, and frame_last on the final
//   interior centre. Border centres give no result.
// Configuration: image_width (index 0) and image_height (index 1) are written
//   via cfg_write / cfg_index / cfg_data; the user must do so only while the
//   block is idle, which the block itself does not enforce.
// Throughput: one pixel per cycle unless in_stall is high; each pixel writes
//   one line buffer bank and reads every bank, and the sorting network takes
//   one window per cycle unless out_stall holds it.
// Path: registered pixel and bank reads, queue, the WIN_N = (2*RADIUS+1)^2
//   rounds of the transposition network, then the output register.
// Reset: counters clear, size returns to 640 x 480, the pipeline empties;
//   the line buffers are not cleared.
// Output stall: the result holds, the network freezes, the window queue
//   takes up to four windows, then in_stall rises.
// ----------------------------------------------------------------------------
module window_median_filter_unit #(
  parameter int RADIUS    = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wmf_pkg::PIX_W-1:0]          pixel_value,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wmf_pkg::PIX_W-1:0]          median_value,
  output logic [wmf_pkg::ROW_W-1:0]          centre_row,
  output logic [wmf_pkg::COL_OUT_W-1:0]      centre_col,
  output logic                               frame_last
);
  import wmf_pkg::*;

  localparam int WIN_N = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int WIN_W = WIN_N * PIX_W;
  localparam int QDW   = WIN_W + $bits(wmf_meta_t);

  wmf_cfg_t         cfg;
  wmf_qstat_t       qstat;
  wmf_meta_t        front_meta, head_meta;
  logic             push, pop;
  logic [WIN_W-1:0] front_win, head_win;
  logic [QDW-1:0]   head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg.width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: cfg.height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  wmf_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .qstat       (qstat),
    .push        (push),
    .win_data    (front_win),
    .meta        (front_meta)
  );

  wmf_queue #(
    .DW (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({front_win, front_meta}),
    .pop       (pop),
    .head_data (head_data),
    .qstat     (qstat)
  );

  assign head_win  = head_data[QDW-1 -: WIN_W];
  assign head_meta = head_data[$bits(wmf_meta_t)-1:0];

  wmf_back #(
    .RADIUS (RADIUS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head_data    (head_win),
    .head_meta    (head_meta),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value),
    .centre_row   (centre_row),
    .centre_col   (centre_col),
    .frame_last   (frame_last)
  );

`ifndef SYNTHESIS
  a_queue_credit: assert property (@(posedge clk) disable iff (rst)
    ((QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(push)) <= (QCNT_W+1)'(QUEUE_DEPTH))
    else $error("window queue overrun");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> !qstat.empty)
    else $error("pushed window missing from queue");
`endif

endmodule

/* rtl/core/wmf_front.sv */
// ----------------------------------------------------------------------------
// Window median filter front end
// Tracks the raster position, writes pixels into the line buffer banks,
// gathers the square window and pushes every interior window into the queue.
// ----------------------------------------------------------------------------
module wmf_front #(
  parameter int RADIUS    = 1,
  parameter int MAX_WIDTH = 1024,
  localparam int WIN_N    = (2 * RADIUS + 1) * (2 * RADIUS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wmf_pkg::wmf_cfg_t              cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wmf_pkg::PIX_W-1:0]      pixel_value,
  input  logic                           frame_start,
  input  wmf_pkg::wmf_qstat_t            qstat,
  output logic                           push,
  output logic [WIN_N*wmf_pkg::PIX_W-1:0] win_data,
  output wmf_pkg::wmf_meta_t             meta
);
  import wmf_pkg::*;

  localparam int WIN_SIDE = 2 * RADIUS + 1;
  localparam int SPAN     = 2 * RADIUS;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int SLOT_W   = $clog2(WIN_SIDE);
  localparam int MW_W     = $clog2(MAX_WIDTH + 1);
  localparam int XW       = (MW_W > WIDTH_REG_W) ? MW_W : WIDTH_REG_W;
  localparam int CXW      = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

  logic [ROW_W-1:0]  row_cnt, row_next, row_cur;
  logic [COL_W-1:0]  col_cnt, col_next, col_cur;
  logic [SLOT_W-1:0] slot_cnt, slot_next, slot_cur;
  logic [XW-1:0]     width_x, eff_w, col_x;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [CXW-1:0]    ccol_x;
  logic              accept, emit, row_end, frame_end;
  wmf_meta_t         meta_cur;

  logic [PIX_W-1:0]  rd_data [WIN_SIDE];

  logic              v1, e1;
  logic [PIX_W-1:0]  pix1;
  logic [SLOT_W-1:0] slot1;

  logic [SLOT_W:0]   sel;
  logic [PIX_W-1:0]  column [WIN_SIDE];
  logic [PIX_W-1:0]  win [WIN_SIDE][WIN_SIDE];
  logic [PIX_W-1:0]  win_next [WIN_SIDE][WIN_SIDE];

  assign push     = v1 && e1;
  assign in_stall = ((QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(push))
                    >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    width_x = XW'(cfg.width);
    if (width_x == '0) begin
      eff_w = XW'(1);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = width_x;
    end
    eff_h = (cfg.height == '0) ? HEIGHT_REG_W'(1) : cfg.height;

    row_cur  = frame_start ? '0 : row_cnt;
    col_cur  = frame_start ? '0 : col_cnt;
    slot_cur = frame_start ? '0 : slot_cnt;
    if (XW'(col_cur) >= eff_w) begin
      col_cur = '0;
    end
    if (row_cur >= eff_h) begin
      row_cur  = '0;
      slot_cur = '0;
    end

    col_x     = XW'(col_cur) + XW'(1);
    row_end   = col_x >= eff_w;
    frame_end = ((ROW_W+1)'(row_cur) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h);
    emit      = (row_cur >= ROW_W'(SPAN)) && (col_cur >= COL_W'(SPAN));

    ccol_x        = CXW'(col_cur) - CXW'(RADIUS);
    meta_cur.row  = row_cur - ROW_W'(RADIUS);
    meta_cur.col  = ccol_x[COL_OUT_W-1:0];
    meta_cur.last = frame_end && row_end;

    col_next  = col_x[COL_W-1:0];
    row_next  = row_cur;
    slot_next = slot_cur;
    if (row_end) begin
      col_next = '0;
      if (frame_end) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = row_cur + ROW_W'(1);
        slot_next = (slot_cur == SLOT_W'(WIN_SIDE - 1)) ? '0 : slot_cur + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
      v1       <= 1'b0;
    end else begin
      v1 <= accept;
      if (accept) begin
        row_cnt  <= row_next;
        col_cnt  <= col_next;
        slot_cnt <= slot_next;
      end
    end
  end

  for (genvar b = 0; b < WIN_SIDE; b++) begin : g_bank
    logic [PIX_W-1:0] bank_mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (accept) begin
        if (slot_cur == SLOT_W'(b)) begin
          bank_mem[col_cur] <= pixel_value;
        end
        rd_data[b] <= bank_mem[col_cur];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e1    <= emit;
      pix1  <= pixel_value;
      slot1 <= slot_cur;
      meta  <= meta_cur;
    end
  end

  always_comb begin
    sel = '0;
    for (int k = 0; k < WIN_SIDE; k++) begin
      sel = (SLOT_W+1)'(slot1) + (SLOT_W+1)'(k + 1);
      if (sel >= (SLOT_W+1)'(WIN_SIDE)) begin
        sel = sel - (SLOT_W+1)'(WIN_SIDE);
      end
      column[k] = (k == SPAN) ? pix1 : rd_data[sel[SLOT_W-1:0]];
    end
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < SPAN; c++) begin
        win_next[r][c] = win[r][c+1];
      end
      win_next[r][SPAN] = column[r];
    end
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE; c++) begin
        win_data[(r*WIN_SIDE+c)*PIX_W +: PIX_W] = win_next[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      win <= win_next;
    end
  end

endmodule

/* rtl/core/wmf_queue.sv */
// ----------------------------------------------------------------------------
// Window median filter queue
// Short register queue of gathered windows between front end and back end.
// ----------------------------------------------------------------------------
module wmf_queue #(
  parameter int DW = 95
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DW-1:0]       push_data,
  input  logic                pop,
  output logic [DW-1:0]       head_data,
  output wmf_pkg::wmf_qstat_t qstat
);
  import wmf_pkg::*;

  logic [DW-1:0]     mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_data   = mem[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

/* rtl/core/wmf_back.sv */
// ----------------------------------------------------------------------------
// Window median filter back end
// Odd-even transposition sorting network, one round per stage, and the
// output register that presents the middle element.
// ----------------------------------------------------------------------------
module wmf_back #(
  parameter int RADIUS = 1,
  localparam int WIN_N = (2 * RADIUS + 1) * (2 * RADIUS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wmf_pkg::wmf_qstat_t             qstat,
  input  logic [WIN_N*wmf_pkg::PIX_W-1:0] head_data,
  input  wmf_pkg::wmf_meta_t              head_meta,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wmf_pkg::PIX_W-1:0]       median_value,
  output logic [wmf_pkg::ROW_W-1:0]       centre_row,
  output logic [wmf_pkg::COL_OUT_W-1:0]   centre_col,
  output logic                            frame_last
);
  import wmf_pkg::*;

  localparam int STAGES = WIN_N;
  localparam int MID    = WIN_N / 2;

  logic             advance;
  logic [PIX_W-1:0] sv   [STAGES][WIN_N];
  logic [PIX_W-1:0] sin  [STAGES][WIN_N];
  logic [PIX_W-1:0] sout [STAGES][WIN_N];
  logic             vld  [STAGES];
  wmf_meta_t        mv   [STAGES];

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !qstat.empty;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      sin[0][i] = head_data[i*PIX_W +: PIX_W];
    end
    for (int k = 1; k < STAGES; k++) begin
      for (int i = 0; i < WIN_N; i++) begin
        sin[k][i] = sv[k-1][i];
      end
    end
    for (int k = 0; k < STAGES; k++) begin
      for (int i = 0; i < WIN_N; i++) begin
        sout[k][i] = sin[k][i];
      end
      for (int i = k % 2; i + 1 < WIN_N; i += 2) begin
        if (sin[k][i] > sin[k][i+1]) begin
          sout[k][i]   = sin[k][i+1];
          sout[k][i+1] = sin[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sv    <= sout;
      mv[0] <= head_meta;
      for (int k = 1; k < STAGES; k++) begin
        mv[k] <= mv[k-1];
      end
      median_value <= sv[STAGES-1][MID];
      centre_row   <= mv[STAGES-1].row;
      centre_col   <= mv[STAGES-1].col;
      frame_last   <= mv[STAGES-1].last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      vld[0] <= pop;
      for (int k = 1; k < STAGES; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[STAGES-1];
    end
  end

endmodule
